FILE: rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants and types of the sliding window maximum unit
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    // default sizes
    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // width of the window length register
    localparam int CFG_W = 7;

    // per-cycle control handed to every cell of the chain
    typedef struct packed {
        logic accept;   // a sample beat is taken this cycle
        logic first;    // the beat starts a new sequence
        logic shift;    // the chain moves one place towards the front
    } t_swm_ctl;

endpackage

`default_nettype wire

FILE: rtl/swm_channels.sv
// ----------------------------------------------------------------------------
// swm channels
// valid/ready channels for samples in and window maxima out
// ----------------------------------------------------------------------------
`default_nettype none

interface swm_in_if #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           first_sample;

    modport source (output valid, output sample, output first_sample, input ready);
    modport sink   (input valid, input sample, input first_sample, output ready);
endinterface

interface swm_out_if #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

`default_nettype wire

FILE: rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// one candidate slot of the monotonic queue chain
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int AGE_W        = 7,
    parameter int AGE_SAT      = swm_pkg::WINDOW_MAX_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire swm_pkg::t_swm_ctl        i_ctl,
    input  wire signed [SAMPLE_WIDTH-1:0] i_sample,
    // neighbour behind this cell
    input  wire                           i_nxt_valid,
    input  wire signed [SAMPLE_WIDTH-1:0] i_nxt_value,
    input  wire        [AGE_W-1:0]        i_nxt_age,
    // neighbour in front survives the new sample
    input  wire                           i_prev_kept,
    output logic                          o_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output logic       [AGE_W-1:0]        o_age,
    output logic                          o_kept,
    output logic signed [SAMPLE_WIDTH-1:0] o_next_value
);
    import swm_pkg::*;

    localparam logic [AGE_W-1:0] AGE_ONE = AGE_W'(1);
    localparam logic [AGE_W-1:0] AGE_TOP = AGE_W'(AGE_SAT);

    logic                           r_valid, n_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_value, n_value;
    logic        [AGE_W-1:0]        r_age, n_age;

    logic                           src_valid;
    logic signed [SAMPLE_WIDTH-1:0] src_value;
    logic        [AGE_W-1:0]        src_age;
    logic                           kept;

    always_comb begin
        src_valid = i_ctl.shift ? i_nxt_valid : r_valid;
        src_value = i_ctl.shift ? i_nxt_value : r_value;
        src_age   = i_ctl.shift ? i_nxt_age   : r_age;
        // equal values are dropped, so only a strictly larger one survives
        kept      = src_valid && (src_value > i_sample) && !i_ctl.first;

        n_valid = r_valid;
        n_value = r_value;
        n_age   = r_age;
        if (i_ctl.accept) begin
            if (kept) begin
                n_valid = 1'b1;
                n_value = src_value;
                n_age   = (src_age == AGE_TOP) ? src_age : src_age + AGE_ONE;
            end else if (i_prev_kept) begin
                n_valid = 1'b1;
                n_value = i_sample;
                n_age   = AGE_ONE;
            end else begin
                n_valid = 1'b0;
            end
        end else if (i_ctl.shift) begin
            n_valid = src_valid;
            n_value = src_value;
            n_age   = src_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

    assign o_valid      = r_valid;
    assign o_value      = r_value;
    assign o_age        = r_age;
    assign o_kept       = kept;
    assign o_next_value = n_value;

    // candidates fall in value towards the back, so survivors form a prefix
    a_kept_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_kept |-> i_prev_kept)
        else $error("survivor behind a dropped candidate");

endmodule

`default_nettype wire

FILE: rtl/swm_obuf.sv
// ----------------------------------------------------------------------------
// swm_obuf
// two-entry result buffer in front of the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module swm_obuf #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_push,
    input  wire signed [SAMPLE_WIDTH-1:0] i_data,
    output logic                          o_full,
    swm_out_if.source                     o_out
);
    import swm_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] r_mem [2];
    logic                           r_wr_ptr, n_wr_ptr;
    logic                           r_rd_ptr, n_rd_ptr;
    logic [1:0]                     r_count, n_count;
    logic                           pop;

    assign pop = o_out.valid && o_out.ready;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full           = (r_count == 2'd2);
    assign o_out.valid      = (r_count != 2'd0);
    assign o_out.window_max = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("result pushed into a full buffer");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer count out of range");

endmodule

`default_nettype wire

FILE: rtl/sliding_window_max_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_max_unit
// streaming maximum over the last window_size samples, monotonic queue
// held in a chain of candidate cells
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_in      in   valid/ready   sample, first_sample
//  o_out     out  valid/ready   window_max
//  cfg       in   i_cfg_we      i_cfg_wdata = window_size
//
//  one sample beat per cycle while i_in.ready is high; the whole queue update
//  happens in the cell row; after a shrink of the window, stale candidates
//  beyond the front one are drained first, during which i_in.ready is low
//  i_rst_n is synchronous: it empties the queue and the result buffer and
//  sets the window to 1
//  a two-entry result buffer decouples o_out; i_in.ready drops when it is full
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_max_unit #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    swm_in_if.sink                    i_in,
    swm_out_if.source                 o_out,
    input  wire                       i_cfg_we,
    input  wire [swm_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import swm_pkg::*;

    // candidate ages and window lengths run from 1 up to WINDOW_MAX
    localparam int               AGE_W   = $clog2(WINDOW_MAX + 1);
    localparam logic [AGE_W-1:0] AGE_ONE = AGE_W'(1);
    localparam logic [AGE_W-1:0] AGE_TOP = AGE_W'(WINDOW_MAX);

    // window length after clamping to 1..WINDOW_MAX
    function automatic logic [AGE_W-1:0] eff_window(input logic [CFG_W-1:0] v);
        logic [AGE_W-1:0] w;
        if (v == '0) begin
            w = AGE_ONE;
        end else if (int'(v) > WINDOW_MAX) begin
            w = AGE_TOP;
        end else begin
            w = AGE_W'(v);
        end
        return w;
    endfunction

    logic [AGE_W-1:0] r_weff;
    logic [AGE_W-1:0] r_seen, n_seen;

    // cell row, index 0 is the queue front (oldest, largest candidate)
    logic [WINDOW_MAX-1:0]          c_valid;
    logic signed [SAMPLE_WIDTH-1:0] c_value  [WINDOW_MAX];
    logic        [AGE_W-1:0]        c_age    [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]          c_kept;
    logic signed [SAMPLE_WIDTH-1:0] c_next   [WINDOW_MAX];

    t_swm_ctl         ctl;
    logic             accept;
    logic             stale_front;
    logic             stale_second;
    logic             buf_full;
    logic             push;
    logic [AGE_W-1:0] seen_clamped;

    // front candidate about to leave the window
    assign stale_front = c_valid[0] && (c_age[0] >= r_weff);

    // a second stale candidate only appears after the window shrank;
    // it is drained one per cycle before the next sample is taken
    generate
        if (WINDOW_MAX > 1) begin : g_second
            assign stale_second = c_valid[1] && (c_age[1] >= r_weff);
        end else begin : g_single
            assign stale_second = 1'b0;
        end
    endgenerate

    assign i_in.ready = !stale_second && !buf_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        ctl.accept = accept;
        ctl.first  = i_in.first_sample;
        ctl.shift  = accept ? stale_front : stale_second;
    end

    // cell row
    generate
        for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
            logic                           nxt_valid;
            logic signed [SAMPLE_WIDTH-1:0] nxt_value;
            logic        [AGE_W-1:0]        nxt_age;
            logic                           prev_kept;

            if (i == WINDOW_MAX - 1) begin : g_tail
                assign nxt_valid = 1'b0;
                assign nxt_value = '0;
                assign nxt_age   = '0;
            end else begin : g_link
                assign nxt_valid = c_valid[i+1];
                assign nxt_value = c_value[i+1];
                assign nxt_age   = c_age[i+1];
            end

            // the front cell takes the sample when it drops its own candidate
            if (i == 0) begin : g_head
                assign prev_kept = 1'b1;
            end else begin : g_body
                assign prev_kept = c_kept[i-1];
            end

            swm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .AGE_W        (AGE_W),
                .AGE_SAT      (WINDOW_MAX)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_sample     (i_in.sample),
                .i_nxt_valid  (nxt_valid),
                .i_nxt_value  (nxt_value),
                .i_nxt_age    (nxt_age),
                .i_prev_kept  (prev_kept),
                .o_valid      (c_valid[i]),
                .o_value      (c_value[i]),
                .o_age        (c_age[i]),
                .o_kept       (c_kept[i]),
                .o_next_value (c_next[i])
            );
        end
    endgenerate

    // fill level of the current sequence, clamped when the window shrank
    always_comb begin
        seen_clamped = (r_seen > r_weff) ? r_weff : r_seen;
        if (i_in.first_sample) begin
            seen_clamped = '0;
        end
        n_seen = r_seen;
        if (accept) begin
            n_seen = (seen_clamped < r_weff) ? seen_clamped + AGE_ONE : seen_clamped;
        end
    end

    // a result leaves once the window is full; it is the new front value
    assign push = accept && (n_seen == r_weff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weff <= AGE_ONE;
            r_seen <= '0;
        end else begin
            if (i_cfg_we) begin
                r_weff <= eff_window(i_cfg_wdata);
            end
            r_seen <= n_seen;
        end
    end

    swm_obuf #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (c_next[0]),
        .o_full  (buf_full),
        .o_out   (o_out)
    );

    // candidates always sit packed at the front of the row
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_valid & (c_valid + 1'b1)) == '0)
        else $error("gap in the candidate row");

    // with a steady window a sample beat leaves at most the front stale
    a_one_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_cfg_we) |=> !stale_second)
        else $error("more than one stale candidate after a sample beat");

endmodule

`default_nettype wire

FILE: tb/sliding_window_max_unit_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_max_unit_tb
// self-checking bench for the running maximum filter: a model of the
// monotonic candidate queue predicts every window maximum, directed cases
// cover the corner values and window edge cases, random sequences run
// under several idling and back-pressure patterns
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_max_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W      = swm_pkg::SAMPLE_WIDTH_DEF;
    localparam int WIN_MAX       = swm_pkg::WINDOW_MAX_DEF;
    localparam int HOLD_CYCLES   = 400;          // long receiver hold-off
    localparam int STALL_LIMIT   = 5000;         // cycles with no beat at all
    localparam int SETTLE_CYCLES = WIN_MAX + 8;  // worst queue clean-up after a shrink
    localparam int MAX_GAP       = 24;

    // clock, reset and config port
    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [swm_pkg::CFG_W-1:0] i_cfg_wdata;

    swm_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) in_ch ();
    swm_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) out_ch ();

    sliding_window_max_unit #(
        .WINDOW_MAX  (WIN_MAX),
        .SAMPLE_WIDTH(SAMPLE_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // 4 ns period
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------------
    // predictor state: candidate queue, positions mod 128, fill count
    // ------------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] cand_val [0:WIN_MAX-1];
    logic [6:0]                 cand_pos [0:WIN_MAX-1];
    logic [5:0]                 q_head;
    logic [6:0]                 q_count;
    logic [6:0]                 pos_ctr;
    logic [6:0]                 fill_cnt;
    logic [6:0]                 win_len;

    logic signed [SAMPLE_W-1:0] expected_max_q [$];

    // run bookkeeping
    int errors;
    int samples_sent;
    int maxima_checked;
    int window_writes;
    int idle_cycles;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;
    bit hold_req;

    // one step of the candidate queue; positions and ages wrap at 7 bits,
    // head and slots at 6 bits, so plain vector arithmetic does the modulo
    task automatic track_window_max(input logic signed [SAMPLE_W-1:0] s, input logic first,
                                    output bit has_max,
                                    output logic signed [SAMPLE_W-1:0] max_val);
        logic [6:0] w;
        logic [6:0] age;
        logic [5:0] back;
        logic [5:0] slot;
        // zero means one, anything past the store size saturates
        if (win_len == 7'd0)
            w = 7'd1;
        else if (win_len > 7'(WIN_MAX))
            w = 7'(WIN_MAX);
        else
            w = win_len;
        if (first) begin
            q_head   = '0;
            q_count  = '0;
            pos_ctr  = '0;
            fill_cnt = '0;
        end
        // expire candidates that fell out of the window at the front
        while (q_count != 0) begin
            age = pos_ctr - cand_pos[q_head];
            if (age < w)
                break;
            q_head  = q_head + 6'd1;
            q_count = q_count - 7'd1;
        end
        // pop back candidates that cannot beat the new sample, ties included
        while (q_count != 0) begin
            back = q_head + q_count[5:0] - 6'd1;
            if (cand_val[back] > s)
                break;
            q_count = q_count - 7'd1;
        end
        if (q_count >= 7'(WIN_MAX)) begin
            q_head  = q_head + 6'd1;
            q_count = q_count - 7'd1;
        end
        slot           = q_head + q_count[5:0];
        cand_val[slot] = s;
        cand_pos[slot] = pos_ctr;
        q_count        = q_count + 7'd1;
        pos_ctr        = pos_ctr + 7'd1;
        if (fill_cnt > w)
            fill_cnt = w;
        if (fill_cnt < w)
            fill_cnt = fill_cnt + 7'd1;
        has_max = (fill_cnt >= w);
        max_val = cand_val[q_head];
    endtask

    // ------------------------------------------------------------------------
    // monitor: predict on every input beat, then check every output beat,
    // both in one process so an input and output in the same edge never race
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit                         has_max;
        logic signed [SAMPLE_W-1:0] max_val;
        logic signed [SAMPLE_W-1:0] want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                track_window_max(in_ch.sample, in_ch.first_sample, has_max, max_val);
                if (has_max)
                    expected_max_q.insert(expected_max_q.size(), max_val);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_max_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected window_max beat: expected none actual %0d",
                             $time, out_ch.window_max);
                end else begin
                    want = expected_max_q[0];
                    expected_max_q.delete(0);
                    maxima_checked++;
                    if (out_ch.window_max !== want) begin
                        errors++;
                        $display("%0t window_max mismatch: expected %0d actual %0d",
                                 $time, want, out_ch.window_max);
                    end
                end
            end
        end
    end

    // watchdog: no beat on either side for too long ends the run
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t timeout: no beat for %0d cycles, %0d maxima outstanding",
                     $time, idle_cycles, expected_max_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off counted down here
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            out_ch.ready = 1'b0;
            hold_left--;
        end else begin
            out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // shared helpers; every task is entered and left just after a falling edge
    // ------------------------------------------------------------------------

    // offer one sample beat, with random idle cycles ahead of it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic first);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.sample       = s;
        in_ch.first_sample = first;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        samples_sent++;
        @(negedge i_clk);
    endtask

    // stop offering, let every predicted maximum arrive, then let any queue
    // clean-up that yields no beat run out
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (expected_max_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [swm_pkg::CFG_W-1:0] len);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = len;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        win_len  = len;
        window_writes++;
    endtask

    // corner values, small values that give plenty of ties, and noise
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(9))
            0:       v = 16'sh7fff;
            1:       v = 16'sh8000;
            2, 3, 4: v = SAMPLE_W'($urandom_range(7)) - 16'sd4;
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    // mostly short windows, with zero, the full store and oversize values
    function automatic logic [swm_pkg::CFG_W-1:0] pick_window();
        case ($urandom_range(19))
            0:       return 7'd0;
            1:       return 7'(WIN_MAX);
            2:       return 7'($urandom_range(WIN_MAX + 1, 127));
            3:       return 7'd127;
            4:       return 7'($urandom_range(16, WIN_MAX - 1));
            5:       return 7'd1;
            default: return 7'($urandom_range(2, 10));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // window of one straight out of reset: every beat is its own maximum
    task automatic test_default_window();
        send_sample(16'sh7fff, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
    endtask

    task automatic test_directed_cases();
        // zero length behaves as one
        write_window(7'd0);
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd2, 1'b0);
        // window of three: ties, a rising step, expiry of an old maximum
        write_window(7'd3);
        send_sample(16'sd5, 1'b1);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(-16'sd8, 1'b0);
        // restart mid-stream: no maximum until the window refills
        send_sample(16'sd2, 1'b1);
        send_sample(16'sd9, 1'b0);
        // shrink mid-sequence, stale candidates go at once
        write_window(7'd2);
        send_sample(-16'sd5, 1'b0);
        // grow mid-sequence, quiet until the longer window is full
        write_window(7'd4);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
    endtask

    // random sequences under one idling pattern; a new window per sequence,
    // now and then carried on without a restart so the change lands mid-stream
    task automatic test_random_stream(input int src_pct, input int sink_pct, input int n_samples);
        int                         done;
        int                         seq_len;
        int                         w;
        logic [swm_pkg::CFG_W-1:0]  len;
        logic                       first;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        done           = 0;
        while (done < n_samples) begin
            len = pick_window();
            write_window(len);
            w = (len == 0) ? 1 : ((len > WIN_MAX) ? WIN_MAX : int'(len));
            seq_len = w + $urandom_range(30);
            // long runs take the position counter through its wrap
            if ($urandom_range(7) == 0)
                seq_len += 150;
            for (int k = 0; k < seq_len; k++) begin
                if (k == 0)
                    first = ($urandom_range(9) != 0);
                else
                    first = ($urandom_range(49) == 0);
                send_sample(pick_sample(), first);
            end
            done += seq_len;
        end
    endtask

    // receiver holds off while the sender keeps offering: the result buffer
    // fills and input ready must drop; afterwards the sender waits for all
    // maxima before it carries on
    task automatic test_backpressure_hold();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_window(7'd1);
        hold_req = 1'b1;
        for (int k = 0; k < 60; k++)
            send_sample(pick_sample(), k == 0);
        wait_drained();
        write_window(7'd5);
        for (int k = 0; k < 20; k++)
            send_sample(pick_sample(), k == 0);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        errors         = 0;
        samples_sent   = 0;
        maxima_checked = 0;
        window_writes  = 0;
        idle_cycles    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 0;
        hold_req       = 1'b0;
        q_head         = '0;
        q_count        = '0;
        pos_ctr        = '0;
        fill_cnt       = '0;
        win_len        = 7'd1;
        for (int k = 0; k < WIN_MAX; k++) begin
            cand_val[k] = '0;
            cand_pos[k] = '0;
        end

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        in_ch.valid        = 1'b0;
        in_ch.sample       = '0;
        in_ch.first_sample = 1'b0;
        out_ch.ready       = 1'b0;

        // hold reset low, then release it
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_window();
        test_directed_cases();
        test_random_stream(0, 0, 280);
        test_random_stream(55, 0, 280);
        test_random_stream(0, 55, 280);
        test_random_stream(33, 33, 280);
        test_backpressure_hold();

        // drain and give the block time to flush anything unexpected
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        wait_drained();

        $display("run covered %0d samples, %0d window maxima checked, %0d window writes",
                 samples_sent, maxima_checked, window_writes);
        $display("idle patterns: none, sender, receiver, both, plus a %0d cycle hold-off",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d errors", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/swm_pkg.sv
rtl/swm_channels.sv
rtl/swm_cell.sv
rtl/swm_obuf.sv
rtl/sliding_window_max_unit.sv
tb/sliding_window_max_unit_tb.sv
